// ===== design/ble_pkg.sv =====
// Package for the bounded list engine: operation and status codes, controller command
// and status structs. It depends on nothing.
package ble_pkg;

  localparam int unsigned FuncW = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 5;

  typedef enum logic [FuncW-1:0] {
    FN_INS_SORTED = 4'd0,
    FN_INS_FRONT  = 4'd1,
    FN_INS_BACK   = 4'd2,
    FN_INS_AT     = 4'd3,
    FN_REM_FRONT  = 4'd4,
    FN_REM_BACK   = 4'd5,
    FN_REM_AT     = 4'd6,
    FN_PEEK_FRONT = 4'd7,
    FN_PEEK_BACK  = 4'd8,
    FN_FIND       = 4'd9,
    FN_READ_AT    = 4'd10,
    FN_CLEAR      = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;   // capture the request
    logic exec;    // decide and update the cells
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic res_valid;
  } dp_sts_t;

endpackage

// ===== design/ble_ctrl.sv =====
// Controller of the bounded list engine: a two-phase sequencer per request.
// Depends on ble_pkg.
module ble_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_busy,
  input  ble_pkg::dp_sts_t sts,
  output ble_pkg::dp_cmd_t cmd,
  output logic             in_ready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_fire;
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // wait for the output register to be free
        if (!out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HOLD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_exec_after_latch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == S_EXEC) else $error("no execute phase after capture");
  a_no_latch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> !in_ready) else $error("ready while executing");
  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !out_busy) else $error("execute over a pending result");
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> sts.res_valid) else $error("result lost");

endmodule

// ===== design/ble_dpath.sv =====
// Datapath of the bounded list engine: a row of entry cells that compare and shift at
// once, plus the output register. Depends on ble_pkg.
module ble_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ble_pkg::dp_cmd_t        cmd,
  input  logic [3:0]              func_in,
  input  logic signed [31:0]      value_in,
  input  logic [4:0]              position_in,
  input  logic                    out_take,
  output ble_pkg::dp_sts_t        sts,
  output logic [1:0]              res_status,
  output logic signed [31:0]      res_value,
  output logic [4:0]              res_position,
  output logic [4:0]              res_count,
  output logic                    res_empty
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic [31:0]       cell_r [CAPACITY];
  logic [CntW-1:0]   count_r, count_nxt;
  logic [3:0]        func_r;
  logic [31:0]       val_r;
  logic [4:0]        pos_r;

  logic              rv_r;
  logic [1:0]        st_r;
  logic [31:0]       vo_r;
  logic [4:0]        po_r;
  logic [CntW-1:0]   co_r;

  // per-cell flags
  logic [CAPACITY-1:0] live, eq, lt;
  logic [CAPACITY-1:0] eq_m;
  logic                hit;
  logic [IdxW-1:0]     hit_idx;
  logic [CntW-1:0]     sort_pos;
  logic                sort_run;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = CntW'(i) < count_r;
      eq[i]   = live[i] && (cell_r[i] == val_r);
      lt[i]   = live[i] && ($signed(cell_r[i]) < $signed(val_r));
    end
    eq_m = eq & ~(eq - 1'b1);
    hit  = |eq;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++)
      if (eq_m[i]) hit_idx = hit_idx | IdxW'(i);
    // entries are sorted only where sorted inserts were used; count the leading run
    sort_pos = '0;
    sort_run = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      sort_run = sort_run && lt[i];
      if (sort_run) sort_pos = CntW'(i + 1);
    end
  end

  // decision
  logic            full, empty;
  logic [CntW-1:0] pos_ext;
  logic [1:0]      st;
  logic            do_ins, do_rem;
  logic [CntW-1:0] at;
  logic [31:0]     vo;
  logic [4:0]      po;

  always_comb begin
    full    = count_r >= CntW'(CAPACITY);
    empty   = count_r == '0;
    pos_ext = (CntW >= 5) ? CntW'(pos_r) : ((pos_r >> CntW) != 0 ? '1 : CntW'(pos_r));
    st = ble_pkg::ST_OK; do_ins = 1'b0; do_rem = 1'b0; at = '0; vo = '0; po = '0;
    count_nxt = count_r;
    unique case (func_r)
      ble_pkg::FN_INS_SORTED: begin
        if (hit) st = ble_pkg::ST_MISS;
        else if (full) st = ble_pkg::ST_FULL;
        else begin do_ins = 1'b1; at = sort_pos; end
      end
      ble_pkg::FN_INS_FRONT, ble_pkg::FN_INS_BACK: begin
        if (full) st = ble_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          at = (func_r == ble_pkg::FN_INS_BACK) ? count_r : '0;
        end
      end
      ble_pkg::FN_INS_AT: begin
        if (full) st = ble_pkg::ST_FULL;
        else if (pos_ext > count_r || (pos_r >> CntW) != 0) st = ble_pkg::ST_BAD;
        else begin do_ins = 1'b1; at = pos_ext; end
      end
      ble_pkg::FN_REM_FRONT, ble_pkg::FN_REM_BACK, ble_pkg::FN_PEEK_FRONT,
      ble_pkg::FN_PEEK_BACK: begin
        if (empty) st = ble_pkg::ST_BAD;
        else begin
          at = (func_r == ble_pkg::FN_REM_BACK || func_r == ble_pkg::FN_PEEK_BACK)
               ? count_r - 1'b1 : '0;
          vo = cell_r[at[IdxW-1:0]];
          do_rem = (func_r == ble_pkg::FN_REM_FRONT || func_r == ble_pkg::FN_REM_BACK);
        end
      end
      ble_pkg::FN_REM_AT, ble_pkg::FN_READ_AT: begin
        if ((pos_r >> CntW) != 0 || pos_ext >= count_r) st = ble_pkg::ST_BAD;
        else begin
          at = pos_ext;
          vo = cell_r[at[IdxW-1:0]];
          do_rem = (func_r == ble_pkg::FN_REM_AT);
        end
      end
      ble_pkg::FN_FIND: begin
        if (hit) po = 5'(hit_idx);
        else st = ble_pkg::ST_MISS;
      end
      ble_pkg::FN_CLEAR: count_nxt = '0;
      default: ;
    endcase
    if (do_ins) count_nxt = count_r + 1'b1;
    if (do_rem) count_nxt = count_r - 1'b1;
  end

  // cells shift toward the back on insert and toward the front on remove
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= func_in;
      val_r  <= value_in;
      pos_r  <= position_in;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) begin
          if (CntW'(i) == at) cell_r[i] <= val_r;
          else if (CntW'(i) > at && i > 0) cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
        end else if (do_rem) begin
          if (CntW'(i) >= at && i < CAPACITY - 1)
            cell_r[i] <= cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
      st_r <= st;
      vo_r <= vo;
      po_r <= po;
      co_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      if (cmd.exec) count_r <= count_nxt;
      if (cmd.exec) rv_r <= 1'b1;
      else if (out_take) rv_r <= 1'b0;
    end
  end

  assign sts.res_valid = rv_r;
  assign res_status    = st_r;
  assign res_value     = vo_r;
  assign res_position  = po_r;
  assign res_count     = 5'(co_r);
  assign res_empty     = co_r == '0;

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY)) else $error("count beyond capacity");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(count_r)) else $error("count moved outside execute");
  a_full_st: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && st == ble_pkg::ST_FULL |-> full) else $error("full status on non-full list");

endmodule

// ===== design/bounded_list_engine_top.sv =====
// Top level of the bounded list engine: stream ports, controller and datapath.
// Depends on ble_pkg, ble_ctrl and ble_dpath.
//
// Usage:
//  One request enters on the in_ stream (tuser = func, tdata = value_in,
//  position_in) and gives exactly one result on the out_ stream (tdata = status,
//  value_out, position_out, count, empty_res). Requests are taken one at a time:
//  a request is captured in one cycle and decided in the execute state once the
//  output register is free, where the row of cells compares all entries at once
//  and shifts them in the same edge. The result appears the cycle after that. No
//  new request is taken until the current one is executed; the sequencer enforces it.
//  When the receiver stalls the result is held in the output register; the next
//  request may be captured meanwhile but is executed only once that result is
//  transferred. After reset the list is empty; entry cells are not cleared.
module bounded_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value_in[31:0], position_in[36:32]
  input  logic [3:0]  in_tuser,   // func[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], value_out[33:2], position_out[38:34],
                                  // count[43:39], empty_res[44]
);

  ble_pkg::dp_cmd_t cmd;
  ble_pkg::dp_sts_t sts;
  logic             in_fire, out_take;
  logic [1:0]       st;
  logic signed [31:0] vo;
  logic [4:0]       po, co;
  logic             em;

  assign in_fire  = in_tvalid && in_tready;
  assign out_take = out_tvalid && out_tready;

  ble_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(sts.res_valid && !out_tready),
    .sts, .cmd, .in_ready(in_tready)
  );

  ble_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk, .rst_n, .cmd,
    .func_in(in_tuser), .value_in(in_tdata[31:0]), .position_in(in_tdata[36:32]),
    .out_take, .sts,
    .res_status(st), .res_value(vo), .res_position(po), .res_count(co), .res_empty(em)
  );

  assign out_tvalid = sts.res_valid;
  assign out_tdata  = {3'b000, em, co, po, vo, st};

endmodule

// ===== sim/list_scoreboard.sv =====
// Checker for the bounded list engine: watches both streams, keeps its own copy of the
// ordered list, predicts each result and compares it field by field. Depends on ble_pkg.
module list_scoreboard #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [4:0]  position;
    logic [4:0]  count;
    logic        empty;
  } list_result_t;

  logic [31:0]  shadow_list [CAPACITY];
  int unsigned  shadow_len;
  list_result_t expected_q [$];

  function automatic list_result_t apply_request(logic [3:0] fn, logic [31:0] v,
                                                 logic [4:0] pos);
    list_result_t r;
    int unsigned i;
    int unsigned hit;
    logic full;
    logic ins;
    int unsigned ins_pos;
    int unsigned rem_pos;
    logic rem;
    r = '0;
    r.status = ble_pkg::ST_OK;
    full = (shadow_len >= CAPACITY);
    ins = 1'b0;
    rem = 1'b0;
    ins_pos = 0;
    rem_pos = 0;
    hit = shadow_len;
    for (i = 0; i < shadow_len; i++)
      if (hit == shadow_len && shadow_list[i] == v) hit = i;
    case (fn)
      ble_pkg::FN_INS_SORTED: begin
        if (hit < shadow_len) r.status = ble_pkg::ST_MISS;
        else if (full) r.status = ble_pkg::ST_FULL;
        else begin
          ins = 1'b1;
          while (ins_pos < shadow_len && $signed(shadow_list[ins_pos]) < $signed(v))
            ins_pos++;
        end
      end
      ble_pkg::FN_INS_FRONT: if (full) r.status = ble_pkg::ST_FULL; else ins = 1'b1;
      ble_pkg::FN_INS_BACK: begin
        if (full) r.status = ble_pkg::ST_FULL;
        else begin
          ins = 1'b1;
          ins_pos = shadow_len;
        end
      end
      ble_pkg::FN_INS_AT: begin
        if (full) r.status = ble_pkg::ST_FULL;
        else if (pos > shadow_len) r.status = ble_pkg::ST_BAD;
        else begin
          ins = 1'b1;
          ins_pos = pos;
        end
      end
      ble_pkg::FN_REM_FRONT: begin
        if (shadow_len == 0) r.status = ble_pkg::ST_BAD;
        else rem = 1'b1;
      end
      ble_pkg::FN_REM_BACK: begin
        if (shadow_len == 0) r.status = ble_pkg::ST_BAD;
        else begin
          rem = 1'b1;
          rem_pos = shadow_len - 1;
        end
      end
      ble_pkg::FN_REM_AT: begin
        if (pos >= shadow_len) r.status = ble_pkg::ST_BAD;
        else begin
          rem = 1'b1;
          rem_pos = pos;
        end
      end
      ble_pkg::FN_PEEK_FRONT: begin
        if (shadow_len == 0) r.status = ble_pkg::ST_BAD;
        else r.value = shadow_list[0];
      end
      ble_pkg::FN_PEEK_BACK: begin
        if (shadow_len == 0) r.status = ble_pkg::ST_BAD;
        else r.value = shadow_list[shadow_len-1];
      end
      ble_pkg::FN_FIND: begin
        if (hit < shadow_len) r.position = 5'(hit);
        else r.status = ble_pkg::ST_MISS;
      end
      ble_pkg::FN_READ_AT: begin
        if (pos >= shadow_len) r.status = ble_pkg::ST_BAD;
        else r.value = shadow_list[pos];
      end
      ble_pkg::FN_CLEAR: shadow_len = 0;
      default: ;
    endcase
    if (ins) begin
      for (i = shadow_len; i > ins_pos; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[ins_pos] = v;
      shadow_len++;
    end
    if (rem) begin
      r.value = shadow_list[rem_pos];
      for (i = rem_pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
      shadow_len--;
    end
    r.count = shadow_len[4:0];
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      fail_count <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_request(in_tuser, in_tdata[31:0], in_tdata[36:32]));
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.value = out_tdata[33:2];
        got.position = out_tdata[38:34];
        got.count = out_tdata[43:39];
        got.empty = out_tdata[44];
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"mismatch: exp st=%0d val=%h pos=%0d cnt=%0d emp=%0b",
                        " / got st=%0d val=%h pos=%0d cnt=%0d emp=%0b"},
                       want.status, want.value, want.position, want.count, want.empty,
                       got.status, got.value, got.position, got.count, got.empty);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = expected_q.size();
endmodule

// ===== sim/bounded_list_engine_top_tb.sv =====
// Testbench top for the bounded list engine: drives directed and random requests with
// random gaps and stalls, and gives the verdict. Depends on ble_pkg and list_scoreboard.
module bounded_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // func codes with no operation behind them
  localparam logic [3:0] FN_UNUSED_LO = 4'd12;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          cycles;
  int          requests_sent;
  logic [31:0] recent_vals [8];

  bounded_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  list_scoreboard #(.CAPACITY(CAPACITY)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall before each result, sometimes none at all.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  task automatic send_request(logic [3:0] fn, logic [31:0] v, logic [4:0] pos, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {3'd0, pos, v};
    in_tuser  <= fn;
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
    requests_sent++;
    recent_vals[$urandom_range(0, 7)] = v;
  endtask

  // Hold off until every outstanding result has been transferred.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  initial begin
    int i;
    int k;
    int sel;
    logic [3:0] fn;
    logic [31:0] v;
    cycles = 0;
    requests_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (i = 0; i < 8; i++) recent_vals[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list failures, extremes, duplicates, fill to full, append at count.
    send_request(ble_pkg::FN_REM_FRONT, 0, 0, 0);
    send_request(ble_pkg::FN_REM_BACK, 0, 0, 1);
    send_request(ble_pkg::FN_PEEK_FRONT, 0, 0, 0);
    send_request(ble_pkg::FN_PEEK_BACK, 0, 0, 2);
    send_request(ble_pkg::FN_FIND, 32'h1234, 0, 0);
    send_request(ble_pkg::FN_READ_AT, 0, 0, 0);
    send_request(ble_pkg::FN_REM_AT, 0, 5'd31, 0);
    send_request(ble_pkg::FN_INS_AT, 32'h5, 5'd1, 0);
    send_request(ble_pkg::FN_INS_SORTED, 32'h7FFF_FFFF, 0, 0);
    send_request(ble_pkg::FN_INS_SORTED, 32'h8000_0000, 0, 0);
    send_request(ble_pkg::FN_INS_SORTED, 32'h8000_0000, 0, 0);
    send_request(ble_pkg::FN_INS_AT, 32'hFFFF_FFFF, 5'd2, 0);
    send_request(ble_pkg::FN_FIND, 32'hFFFF_FFFF, 0, 0);
    send_request(FN_UNUSED_HI, 32'hFFFF_FFFF, 5'd31, 0);
    send_request(FN_UNUSED_LO, 0, 0, 0);
    for (i = 0; i < 14; i++) send_request(ble_pkg::FN_INS_FRONT, $urandom, 0, 0);
    send_request(ble_pkg::FN_INS_BACK, 1, 0, 0);
    send_request(ble_pkg::FN_INS_AT, 2, 5'd16, 0);
    send_request(ble_pkg::FN_INS_SORTED, 32'h7FFF_FFFF, 0, 0);
    send_request(ble_pkg::FN_READ_AT, 0, 5'd15, 0);
    send_request(ble_pkg::FN_READ_AT, 0, 5'd16, 0);
    send_request(ble_pkg::FN_REM_AT, 0, 5'd15, 0);
    send_request(ble_pkg::FN_CLEAR, 0, 0, 0);

    drain();

    for (k = 0; k < 1525; k++) begin
      sel = $urandom_range(0, 99);
      v = ($urandom_range(0, 3) == 0) ? recent_vals[$urandom_range(0, 7)]
          : (($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20) - 10);
      if (sel < 40)
        fn = 4'($urandom_range(ble_pkg::FN_INS_SORTED, ble_pkg::FN_INS_AT));
      else if (sel < 70)
        fn = 4'($urandom_range(ble_pkg::FN_REM_FRONT, ble_pkg::FN_REM_AT));
      else if (sel < 97)
        fn = 4'($urandom_range(ble_pkg::FN_PEEK_FRONT, ble_pkg::FN_READ_AT));
      else if (sel < 99) fn = ble_pkg::FN_CLEAR;
      else fn = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      send_request(fn, v, 5'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 31 : 16)),
                   ($urandom_range(0, 9) < 3) ? 0 : draw_gap());
      if (k == 700) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests covering every operation, full and empty lists,", requests_sent);
    $display("and checked %0d results under random gaps and stalls.", results_seen);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
design/ble_pkg.sv
design/ble_ctrl.sv
design/ble_dpath.sv
design/bounded_list_engine_top.sv
sim/list_scoreboard.sv
sim/bounded_list_engine_top_tb.sv
